>>> sv/ahfe_pkg.sv
// Shared types and constants for the ARP header field extractor.
// Used by ahfe_front, ahfe_queue, ahfe_back and arp_header_field_extractor.
// Depends on nothing.
package ahfe_pkg;

    localparam int unsigned CountWidth = 11;
    localparam logic [CountWidth-1:0] CountMax = 11'd2047;
    localparam logic [CountWidth-1:0] FixedLen = 11'd8;
    localparam logic [CountWidth-1:0] Ipv4Len = 11'd4;
    localparam logic [15:0] EthertypeIpv4 = 16'h0800;
    localparam logic [7:0] Ipv4AddrSize = 8'd4;

    localparam logic [CountWidth-1:0] PosHwTypeEnd = 11'd2;
    localparam logic [CountWidth-1:0] PosProtoTypeEnd = 11'd4;
    localparam logic [CountWidth-1:0] PosHwSize = 11'd4;
    localparam logic [CountWidth-1:0] PosProtoSize = 11'd5;
    localparam logic [CountWidth-1:0] PosOpcode = 11'd6;

    localparam int unsigned OutDataWidth = 136;

    typedef struct packed {
        logic [CountWidth-1:0] byte_count;
        logic [15:0]           hw_type;
        logic [15:0]           proto_type;
        logic [7:0]            hw_size;
        logic [7:0]            proto_size;
        logic [15:0]           opcode;
        logic [31:0]           sender_ip;
        logic [31:0]           target_ip;
    } capture_t;

    typedef struct packed {
        logic        parse_status;
        logic        fixed_part_short;
        logic        address_part_short;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_addr_size;
        logic [7:0]  proto_addr_size;
        logic [15:0] op_code;
        logic        has_ipv4_pair;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> sv/ahfe_front.sv
// Front end: accepts packet words, counts bytes and captures header fields.
// On the last word it pushes the raw capture record into the queue.
// Depends on ahfe_pkg.
module ahfe_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    input  logic                in_byte_valid,
    input  logic                in_last,
    output logic                in_ready,
    input  ahfe_pkg::queue_status_t queue_status,
    output logic                push,
    output ahfe_pkg::capture_t  push_rec
);

    ahfe_pkg::capture_t cap_reg;
    ahfe_pkg::capture_t cap_next;
    ahfe_pkg::capture_t upd;
    logic               accept;
    logic [ahfe_pkg::CountWidth-1:0] pos;
    logic [ahfe_pkg::CountWidth-1:0] declared;
    logic [ahfe_pkg::CountWidth-1:0] s_off;
    logic [ahfe_pkg::CountWidth-1:0] t_off;

    assign in_ready = !queue_status.full;
    assign accept   = in_valid && in_ready;
    assign pos      = cap_reg.byte_count;

    assign declared = ahfe_pkg::FixedLen
                    + {2'b0, cap_reg.hw_size, 1'b0}
                    + {2'b0, cap_reg.proto_size, 1'b0};
    assign s_off    = ahfe_pkg::FixedLen + {3'b0, cap_reg.hw_size};
    assign t_off    = ahfe_pkg::FixedLen + {2'b0, cap_reg.hw_size, 1'b0}
                    + {3'b0, cap_reg.proto_size};

    always_comb
    begin
        upd = cap_reg;
        priority if (pos < ahfe_pkg::PosHwTypeEnd)
        begin
            upd.hw_type = {cap_reg.hw_type[7:0], in_byte};
        end
        else if (pos < ahfe_pkg::PosProtoTypeEnd)
        begin
            upd.proto_type = {cap_reg.proto_type[7:0], in_byte};
        end
        else if (pos == ahfe_pkg::PosHwSize)
        begin
            upd.hw_size = in_byte;
        end
        else if (pos == ahfe_pkg::PosProtoSize)
        begin
            upd.proto_size = in_byte;
        end
        else if (pos < ahfe_pkg::FixedLen)
        begin
            upd.opcode = {cap_reg.opcode[7:0], in_byte};
        end
        else
        begin
            if (pos < declared)
            begin
                if (pos >= s_off && pos < s_off + ahfe_pkg::Ipv4Len)
                begin
                    upd.sender_ip = {cap_reg.sender_ip[23:0], in_byte};
                end
                if (pos >= t_off && pos < t_off + ahfe_pkg::Ipv4Len)
                begin
                    upd.target_ip = {cap_reg.target_ip[23:0], in_byte};
                end
            end
        end
        if (pos < ahfe_pkg::CountMax)
        begin
            upd.byte_count = pos + 11'd1;
        end
    end

    always_comb
    begin
        push_rec = in_byte_valid ? upd : cap_reg;
        push     = accept && in_last;
        cap_next = cap_reg;
        if (accept)
        begin
            cap_next = in_last ? '0 : push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= '0;
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

endmodule

>>> sv/ahfe_queue.sv
// Short queue of capture records between the front and back ends.
// Depth is set by DEPTH (at least 2).
// Depends on ahfe_pkg.
module ahfe_queue
#(
    parameter int unsigned DEPTH = 2
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  ahfe_pkg::capture_t      push_rec,
    input  logic                    pop,
    output ahfe_pkg::capture_t      head_rec,
    output ahfe_pkg::queue_status_t status
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    ahfe_pkg::capture_t store [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_rec     = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> sv/ahfe_back.sv
// Back end: classifies the queued capture record and holds it in the output register.
// Loads a new result whenever a record is queued and the output register is empty or being taken.
// Depends on ahfe_pkg.
module ahfe_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ahfe_pkg::capture_t      head_rec,
    input  ahfe_pkg::queue_status_t queue_status,
    output logic                    pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output ahfe_pkg::result_t       result
);

    logic                            out_valid_reg;
    logic                            out_valid_next;
    ahfe_pkg::result_t               result_reg;
    ahfe_pkg::result_t               result_next;
    logic [ahfe_pkg::CountWidth-1:0] n;
    logic [ahfe_pkg::CountWidth-1:0] declared;
    logic                            fshort;
    logic                            ashort;
    logic                            ipv4;

    assign n        = head_rec.byte_count;
    assign declared = ahfe_pkg::FixedLen
                    + {2'b0, head_rec.hw_size, 1'b0}
                    + {2'b0, head_rec.proto_size, 1'b0};
    assign fshort   = n < ahfe_pkg::FixedLen;
    assign ashort   = !fshort && n < declared;
    assign ipv4     = !fshort && !ashort
                    && head_rec.proto_type == ahfe_pkg::EthertypeIpv4
                    && head_rec.proto_size == ahfe_pkg::Ipv4AddrSize;

    assign pop       = !queue_status.empty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        result_next.parse_status       = fshort || ashort;
        result_next.fixed_part_short   = fshort;
        result_next.address_part_short = ashort;
        result_next.hw_type    = (n >= ahfe_pkg::PosHwTypeEnd) ? head_rec.hw_type : '0;
        result_next.proto_type = (n >= ahfe_pkg::PosProtoTypeEnd) ? head_rec.proto_type : '0;
        result_next.hw_addr_size = (n > ahfe_pkg::PosHwSize) ? head_rec.hw_size : '0;
        result_next.proto_addr_size = (n > ahfe_pkg::PosProtoSize) ? head_rec.proto_size : '0;
        result_next.op_code       = fshort ? '0 : head_rec.opcode;
        result_next.has_ipv4_pair = ipv4;
        result_next.sender_ip     = ipv4 ? head_rec.sender_ip : '0;
        result_next.target_ip     = ipv4 ? head_rec.target_ip : '0;

        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> sv/arp_header_field_extractor.sv
// Channel   Dir  Words                          Signals
// s_axis    in   one packet byte per word       s_tvalid s_tready s_tdata s_tuser s_tlast
// m_axis    out  one parse result per packet    m_tvalid m_tready m_tdata
//
// Takes one word per cycle while s_tready is high; byte capture is a single register update.
// When the last word is taken, its record enters the queue, then moves to the output register.
// Reset clears the byte counter, the captured fields, the queue and the output valid flag.
// s_tready falls only while the QUEUE_DEPTH-entry record queue is full.
// Top level of the ARP header field extractor; instantiates ahfe_front, ahfe_queue, ahfe_back.
// Depends on ahfe_pkg.
module arp_header_field_extractor
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // data_byte
    input  logic                              s_tuser,  // byte_valid
    input  logic                              s_tlast,  // last_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // parse_status, fixed_part_short, address_part_short, hw_type, proto_type,
    // hw_addr_size, proto_addr_size, op_code, has_ipv4_pair, sender_ip, target_ip, zero pad
    output logic [ahfe_pkg::OutDataWidth-1:0] m_tdata
);

    ahfe_pkg::queue_status_t queue_status;
    ahfe_pkg::capture_t      push_rec;
    ahfe_pkg::capture_t      head_rec;
    ahfe_pkg::result_t       result;
    logic                    push;
    logic                    pop;

    ahfe_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_byte      (s_tdata),
        .in_byte_valid(s_tuser),
        .in_last      (s_tlast),
        .in_ready     (s_tready),
        .queue_status (queue_status),
        .push         (push),
        .push_rec     (push_rec)
    );

    ahfe_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .status   (queue_status)
    );

    ahfe_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_rec     (head_rec),
        .queue_status (queue_status),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .result       (result)
    );

    assign m_tdata = {4'b0,
                      result.target_ip,
                      result.sender_ip,
                      result.has_ipv4_pair,
                      result.op_code,
                      result.proto_addr_size,
                      result.hw_addr_size,
                      result.proto_type,
                      result.hw_type,
                      result.address_part_short,
                      result.fixed_part_short,
                      result.parse_status};

`ifndef NO_ASSERTIONS
    a_short_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(result.fixed_part_short && result.address_part_short))
        else $error("both truncation flags set");

    a_status_matches: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (result.parse_status
                      == (result.fixed_part_short || result.address_part_short)))
        else $error("parse status disagrees with truncation flags");

    a_ipv4_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && result.has_ipv4_pair) |-> !result.parse_status)
        else $error("address pair reported on a truncated packet");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        queue_status.empty |-> s_tready)
        else $error("input stalled with an empty queue");
`endif

endmodule

>>> tb/tb_arp_header_field_extractor.sv
// Self-checking bench for arp_header_field_extractor: streams ARP packets byte by byte and
// compares every parse result against a cycle-free model of the header capture kept in this file.
// Depends on ahfe_pkg and the arp_header_field_extractor RTL.
module tb_arp_header_field_extractor;

    typedef logic [7:0] arp_bytes_t[$];

    localparam int unsigned StallLimit = 2000;
    localparam int unsigned RandomWords = 1000;
    localparam int unsigned RandomPackets = 20;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [7:0] s_tdata;
    logic s_tuser;
    logic s_tlast;
    logic m_tvalid;
    logic m_tready;
    logic [ahfe_pkg::OutDataWidth-1:0] m_tdata;

    logic [ahfe_pkg::CountWidth-1:0] pkt_len = '0;
    logic [15:0] hw_type_q = '0;
    logic [15:0] proto_type_q = '0;
    logic [7:0] hw_size_q = '0;
    logic [7:0] proto_size_q = '0;
    logic [15:0] opcode_q = '0;
    logic [31:0] sender_ip_q = '0;
    logic [31:0] target_ip_q = '0;

    ahfe_pkg::result_t arp_results_due[$];
    int unsigned field_errors = 0;
    bit tx_gaps_on = 1'b1;
    bit rx_stalls_on = 1'b1;

    arp_header_field_extractor u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int unsigned declared_len();
        return 32'(ahfe_pkg::FixedLen) + 2 * 32'(hw_size_q) + 2 * 32'(proto_size_q);
    endfunction

    task automatic take_arp_byte(input logic [7:0] b);
        int unsigned pos;
        int unsigned s_off;
        int unsigned t_off;
        pos = pkt_len;
        s_off = 32'(ahfe_pkg::FixedLen) + 32'(hw_size_q);
        t_off = 32'(ahfe_pkg::FixedLen) + 2 * 32'(hw_size_q) + 32'(proto_size_q);
        if (pos < ahfe_pkg::PosHwTypeEnd)
        begin
            hw_type_q = {hw_type_q[7:0], b};
        end
        else if (pos < ahfe_pkg::PosProtoTypeEnd)
        begin
            proto_type_q = {proto_type_q[7:0], b};
        end
        else if (pos == ahfe_pkg::PosHwSize)
        begin
            hw_size_q = b;
        end
        else if (pos == ahfe_pkg::PosProtoSize)
        begin
            proto_size_q = b;
        end
        else if (pos < ahfe_pkg::FixedLen)
        begin
            opcode_q = {opcode_q[7:0], b};
        end
        else if (pos < declared_len())
        begin
            if (pos >= s_off && pos < s_off + ahfe_pkg::Ipv4Len)
            begin
                sender_ip_q = {sender_ip_q[23:0], b};
            end
            if (pos >= t_off && pos < t_off + ahfe_pkg::Ipv4Len)
            begin
                target_ip_q = {target_ip_q[23:0], b};
            end
        end
        if (pkt_len != ahfe_pkg::CountMax)
        begin
            pkt_len = pkt_len + 1'b1;
        end
    endtask

    task automatic close_arp_packet();
        ahfe_pkg::result_t res;
        int unsigned n;
        logic fshort;
        logic ashort;
        logic ipv4;
        n = pkt_len;
        fshort = n < ahfe_pkg::FixedLen;
        ashort = !fshort && n < declared_len();
        ipv4 = !fshort && !ashort && proto_type_q == ahfe_pkg::EthertypeIpv4
            && proto_size_q == ahfe_pkg::Ipv4AddrSize;
        res.parse_status = fshort || ashort;
        res.fixed_part_short = fshort;
        res.address_part_short = ashort;
        res.hw_type = (n >= ahfe_pkg::PosHwTypeEnd) ? hw_type_q : '0;
        res.proto_type = (n >= ahfe_pkg::PosProtoTypeEnd) ? proto_type_q : '0;
        res.hw_addr_size = (n >= ahfe_pkg::PosProtoSize) ? hw_size_q : '0;
        res.proto_addr_size = (n >= ahfe_pkg::PosOpcode) ? proto_size_q : '0;
        res.op_code = fshort ? '0 : opcode_q;
        res.has_ipv4_pair = ipv4;
        res.sender_ip = ipv4 ? sender_ip_q : '0;
        res.target_ip = ipv4 ? target_ip_q : '0;
        arp_results_due.push_back(res);
        pkt_len = '0;
        hw_type_q = '0;
        proto_type_q = '0;
        hw_size_q = '0;
        proto_size_q = '0;
        opcode_q = '0;
        sender_ip_q = '0;
        target_ip_q = '0;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            field_errors++;
            if (field_errors <= 10)
            begin
                $display("%s mismatch: expected %h, got %h", name, exp_v, act_v);
            end
        end
    endtask

    task automatic check_word(input ahfe_pkg::result_t res,
                              input logic [ahfe_pkg::OutDataWidth-1:0] w);
        check_field("parse_status", res.parse_status, w[0]);
        check_field("fixed_part_short", res.fixed_part_short, w[1]);
        check_field("address_part_short", res.address_part_short, w[2]);
        check_field("hw_type", res.hw_type, w[18:3]);
        check_field("proto_type", res.proto_type, w[34:19]);
        check_field("hw_addr_size", res.hw_addr_size, w[42:35]);
        check_field("proto_addr_size", res.proto_addr_size, w[50:43]);
        check_field("op_code", res.op_code, w[66:51]);
        check_field("has_ipv4_pair", res.has_ipv4_pair, w[67]);
        check_field("sender_ip", res.sender_ip, w[99:68]);
        check_field("target_ip", res.target_ip, w[131:100]);
        check_field("padding", '0, w[135:132]);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (arp_results_due.size() == 0)
            begin
                field_errors++;
                if (field_errors <= 10)
                begin
                    $display("Unexpected result word %h.", m_tdata);
                end
            end
            else
            begin
                check_word(arp_results_due.pop_front(), m_tdata);
            end
        end
    end

    initial
    begin : rx_pacing
        int unsigned run;
        int unsigned r;
        run = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rx_stalls_on)
            begin
                m_tready <= 1'b1;
            end
            else if (run != 0)
            begin
                run--;
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 65)
                begin
                    m_tready <= 1'b1;
                    run = $urandom_range(0, 15);
                end
                else if (r < 95)
                begin
                    m_tready <= 1'b0;
                    run = $urandom_range(0, 2);
                end
                else
                begin
                    m_tready <= 1'b0;
                    run = $urandom_range(10, 40);
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned idle;
        idle = 0;
        while (idle < StallLimit)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle = 0;
            end
            else
            begin
                idle++;
            end
        end
        $display("tb_arp_header_field_extractor failed");
        $finish;
    end

    function automatic int unsigned sender_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (!tx_gaps_on || r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic send_word(input logic [7:0] data, input logic valid, input logic last);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tuser <= valid;
        s_tlast <= last;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        if (valid)
        begin
            take_arp_byte(data);
        end
        if (last)
        begin
            close_arp_packet();
        end
        gap = sender_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (arp_results_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_arp_packet(input arp_bytes_t body, input bit close_empty,
                                   input bit noisy);
        int unsigned i;
        for (i = 0; i < body.size(); i++)
        begin
            if (noisy && $urandom_range(3) == 0)
            begin
                send_word(8'($urandom_range(255)), 1'b0, 1'b0);
            end
            send_word(body[i], 1'b1, !close_empty && i == body.size() - 1);
        end
        if (close_empty || body.size() == 0)
        begin
            send_word(8'($urandom_range(255)), 1'b0, 1'b1);
        end
    endtask

    function automatic arp_bytes_t build_arp(input logic [15:0] hw_type,
                                             input logic [15:0] proto_type,
                                             input logic [7:0] hw_size,
                                             input logic [7:0] proto_size,
                                             input logic [15:0] opcode);
        arp_bytes_t body;
        int unsigned addr_len;
        addr_len = 2 * 32'(hw_size) + 2 * 32'(proto_size);
        body = {hw_type[15:8], hw_type[7:0], proto_type[15:8], proto_type[7:0],
                hw_size, proto_size, opcode[15:8], opcode[7:0]};
        repeat (addr_len) body.push_back(8'($urandom_range(255)));
        return body;
    endfunction

    task automatic test_empty_and_ignored();
        arp_bytes_t none;
        send_arp_packet(none, 1'b1, 1'b0);
        send_word(8'hA5, 1'b0, 1'b0);
        send_arp_packet(none, 1'b1, 1'b0);
    endtask

    task automatic test_short_header();
        arp_bytes_t body;
        body = {8'hFF, 8'h00, 8'h08};
        send_arp_packet(body, 1'b1, 1'b0);
    endtask

    task automatic test_ipv4_with_trailer();
        arp_bytes_t body;
        body = build_arp(16'hFFFF, ahfe_pkg::EthertypeIpv4, 8'd0, ahfe_pkg::Ipv4AddrSize,
                         16'h0000);
        body.push_back(8'h00);
        body.push_back(8'hFF);
        send_arp_packet(body, 1'b0, 1'b0);
    endtask

    task automatic test_random_packets();
        arp_bytes_t body;
        int unsigned words;
        int unsigned packets;
        int unsigned r;
        int unsigned cut;
        bit close_empty;
        logic [7:0] hw_size;
        logic [7:0] proto_size;
        logic [15:0] proto_type;
        words = 0;
        packets = 0;
        while (words < RandomWords || packets < RandomPackets)
        begin
            r = $urandom_range(99);
            hw_size = (r < 70) ? 8'($urandom_range(0, 8)) :
                      (r < 98) ? 8'($urandom_range(0, 24)) : 8'($urandom_range(0, 255));
            proto_type = ($urandom_range(3) != 0) ? ahfe_pkg::EthertypeIpv4
                                                   : 16'($urandom_range(65535));
            proto_size = ($urandom_range(3) != 0) ? ahfe_pkg::Ipv4AddrSize
                                                   : 8'($urandom_range(0, 12));
            body = build_arp(16'($urandom_range(65535)), proto_type, hw_size, proto_size,
                             16'($urandom_range(65535)));
            r = $urandom_range(99);
            if (r < 20)
            begin
                cut = $urandom_range(0, body.size() - 1);
                while (body.size() > cut)
                begin
                    void'(body.pop_back());
                end
            end
            else if (r < 35)
            begin
                repeat ($urandom_range(1, 5)) body.push_back(8'($urandom_range(255)));
            end
            close_empty = ($urandom_range(3) == 0) || body.size() == 0;
            tx_gaps_on = ($urandom_range(4) != 0);
            rx_stalls_on = ($urandom_range(4) != 0);
            if ($urandom_range(11) == 0)
            begin
                wait_results_drained();
            end
            send_arp_packet(body, close_empty, $urandom_range(9) == 0);
            words += body.size() + (close_empty ? 1 : 0);
            packets++;
        end
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        s_tlast <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_and_ignored();
        test_short_header();
        test_ipv4_with_trailer();
        wait_results_drained();
        test_random_packets();
        wait_results_drained();
        repeat (8) @(posedge clk);
        if (field_errors == 0 && arp_results_due.size() == 0)
        begin
            $display("tb_arp_header_field_extractor passed");
        end
        else
        begin
            $display("tb_arp_header_field_extractor failed");
        end
        $finish;
    end

endmodule
